>>> hw/rtl/asaa_pkg.sv
// Shared types, command codes and mask helpers for the aligned square atlas allocator.
// Used by asaa_band_check and aligned_square_atlas_allocator_top; depends on nothing.
`default_nettype none

package asaa_pkg;

	localparam int GRID    = 32;
	localparam int COORD_W = $clog2(GRID);
	localparam int CNT_W   = COORD_W + 1;
	localparam int LOG_W   = 3;
	localparam logic [LOG_W-1:0] MAX_LOG = LOG_W'(COORD_W);

	typedef logic [GRID-1:0] asaa_row_t;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_ALLOCATE = 2'd1,
		CMD_RESERVE  = 2'd2
	} asaa_cmd_code_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [LOG_W-1:0]   size_log;
		logic [COORD_W-1:0] want_x;
		logic [COORD_W-1:0] want_y;
	} asaa_req_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] placed_x;
		logic [COORD_W-1:0] placed_y;
	} asaa_rsp_t;

	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] x;
	} asaa_hit_t;

	// Square side minus one, valid for sides that fit the grid.
	function automatic logic [COORD_W-1:0] side_mask(input logic [LOG_W-1:0] slog);
		logic [CNT_W-1:0] s;
		s = (CNT_W'(1) << slog) - CNT_W'(1);
		return s[COORD_W-1:0];
	endfunction

	// Columns covered by a square of side 2**slog whose first column is x.
	function automatic asaa_row_t span_mask(input logic [LOG_W-1:0] slog,
			input logic [COORD_W-1:0] x);
		logic [CNT_W-1:0] side;
		asaa_row_t ones;
		side = CNT_W'(1) << slog;
		ones = ~({GRID{1'b1}} << side);
		return ones << x;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/asaa_band_check.sv
// Per-row test of all aligned column positions of a band, plus first-fit selection.
// Depends on asaa_pkg.
`default_nettype none

module asaa_band_check (
	input  asaa_pkg::asaa_row_t          row,
	input  asaa_pkg::asaa_row_t          acc,
	input  asaa_pkg::asaa_row_t          pick,
	input  logic [asaa_pkg::LOG_W-1:0]   slog,
	output asaa_pkg::asaa_row_t          acc_next,
	output asaa_pkg::asaa_hit_t          hit
);
	import asaa_pkg::*;

	logic [COORD_W-1:0] smask;
	asaa_row_t          free;
	asaa_row_t          sel;

	// A position stays a candidate only while every row of the band is free under it.
	always_comb begin
		smask = side_mask(slog);
		for (int i = 0; i < GRID; i++) begin
			free[i] = ((COORD_W'(i) & smask) == '0) &&
				((row & span_mask(slog, COORD_W'(i))) == '0);
		end
		acc_next = acc & free;
		sel      = acc_next & pick;
		hit.hit  = |sel;
		hit.x    = '0;
		for (int i = GRID - 1; i >= 0; i--) begin
			if (sel[i]) begin
				hit.x = COORD_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/aligned_square_atlas_allocator_top.sv
// Aligned square atlas allocator: 32x32 occupancy bitmap with first-fit square placement.
// Clear and rejected commands answer without leaving idle; reserve scans its own band and
// allocate scans up to all 32 rows, one row per cycle, and the band of a placed square is then
// read again and written back. Throughput: one transaction at a time; busy stays high until
// the result strobe, set by the single bitmap read port feeding the band checker.
// Reset clears the bitmap through per-row valid flops at once; results cannot be stalled.
`default_nettype none

module aligned_square_atlas_allocator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  asaa_pkg::asaa_req_t  req,
	output logic                 busy,
	output logic                 done,
	output asaa_pkg::asaa_rsp_t  rsp
);
	import asaa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_MARK = 3'b100
	} asaa_state_t;

	asaa_state_t        state_q;
	logic               done_q;
	asaa_rsp_t          rsp_q;

	// Transaction context captured at acceptance.
	logic [LOG_W-1:0]   slog_q;
	logic               rsv_q;
	logic [COORD_W-1:0] wx_q;
	logic [COORD_W-1:0] px_q;

	// Row sequencer: iss_q is the next row to read, end_q one past the last row.
	logic [CNT_W-1:0]   iss_q;
	logic [CNT_W-1:0]   end_q;
	logic               dv_q;
	logic [COORD_W-1:0] drow_q;
	asaa_row_t          acc_q;

	// Bitmap storage. A row whose valid bit is low reads as empty, so a clear only drops the valid bits.
	asaa_row_t          mem_q [GRID];
	logic [GRID-1:0]    vld_q;
	asaa_row_t          rdata_q;

	logic               rd_en;
	logic               wr_en;
	asaa_row_t          wr_data;
	logic [COORD_W-1:0] smask;
	logic [CNT_W-1:0]   side;
	asaa_row_t          pick;
	logic               band_end;
	logic               last_row;
	logic [COORD_W-1:0] band_y;
	logic               clr_go;
	asaa_row_t          acc_next;
	asaa_hit_t          hit;

	// Request decode helpers for the accept cycle.
	logic [COORD_W-1:0] req_smask;
	logic [CNT_W-1:0]   req_side;
	logic               req_big;
	logic               req_misaligned;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_comb begin
		smask     = side_mask(slog_q);
		side      = CNT_W'(1) << slog_q;
		pick      = rsv_q ? (GRID'(1) << wx_q) : '1;
		rd_en     = (state_q != ST_IDLE) && (iss_q < end_q);
		band_end  = dv_q && ((drow_q & smask) == smask);
		last_row  = ({1'b0, drow_q} == (end_q - CNT_W'(1)));
		band_y    = drow_q & ~smask;
		wr_en     = (state_q == ST_MARK) && dv_q;
		wr_data   = rdata_q | span_mask(slog_q, px_q);
		clr_go    = (state_q == ST_IDLE) && start && (req.command == CMD_CLEAR);

		req_big        = (req.size_log > MAX_LOG);
		req_smask      = side_mask(req.size_log);
		req_side       = CNT_W'(1) << req.size_log;
		req_misaligned = ((req.want_x & req_smask) != '0) || ((req.want_y & req_smask) != '0);
	end

	// The shared band checker folds one bitmap row per cycle into the candidate vector.
	asaa_band_check u_band (
		.row      (rdata_q),
		.acc      (acc_q),
		.pick     (pick),
		.slog     (slog_q),
		.acc_next (acc_next),
		.hit      (hit)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[drow_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= vld_q[iss_q[COORD_W-1:0]] ? mem_q[iss_q[COORD_W-1:0]] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_go) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[drow_q] <= 1'b1;
		end
	end

	// Sequencer. A scan walks rows band by band; on a hit the band's rows are
	// read again and written back with the square's columns set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			slog_q  <= '0;
			rsv_q   <= 1'b0;
			wx_q    <= '0;
			px_q    <= '0;
			iss_q   <= '0;
			end_q   <= '0;
			dv_q    <= 1'b0;
			drow_q  <= '0;
			acc_q   <= '1;
		end else begin
			done_q <= 1'b0;
			if (rd_en) begin
				iss_q  <= iss_q + CNT_W'(1);
				dv_q   <= 1'b1;
				drow_q <= iss_q[COORD_W-1:0];
			end else begin
				dv_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						slog_q <= req.size_log;
						rsv_q  <= (req.command == CMD_RESERVE);
						wx_q   <= req.want_x;
						acc_q  <= '1;
						dv_q   <= 1'b0;
						rsp_q  <= '0;
						case (req.command)
							CMD_CLEAR: begin
								rsp_q.ok <= 1'b1;
								done_q   <= 1'b1;
							end
							CMD_ALLOCATE: begin
								if (req_big) begin
									done_q <= 1'b1;
								end else begin
									iss_q   <= '0;
									end_q   <= CNT_W'(GRID);
									state_q <= ST_SCAN;
								end
							end
							CMD_RESERVE: begin
								if (req_big || req_misaligned) begin
									done_q <= 1'b1;
								end else begin
									iss_q   <= {1'b0, req.want_y};
									end_q   <= {1'b0, req.want_y} + req_side;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (dv_q) begin
						if (band_end) begin
							if (hit.hit) begin
								px_q    <= hit.x;
								rsp_q.placed_x <= hit.x;
								rsp_q.placed_y <= band_y;
								iss_q   <= {1'b0, band_y};
								end_q   <= {1'b0, band_y} + side;
								dv_q    <= 1'b0;
								state_q <= ST_MARK;
							end else if (last_row) begin
								rsp_q   <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								acc_q <= '1;
							end
						end else begin
							acc_q <= acc_next;
						end
					end
				end
				ST_MARK: begin
					if (dv_q && last_row) begin
						rsp_q.ok <= 1'b1;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The result strobe always coincides with the block being free for the next transaction.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A failed transaction reports a zero corner.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ok) |-> (rsp.placed_x == '0 && rsp.placed_y == '0))
		else $error("failed result with nonzero corner");

	// An accepted transaction either finishes at once or holds the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction dropped");

	// A placed square is aligned to its own side.
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.ok && !$past(clr_go)) |->
			(((rsp.placed_x | rsp.placed_y) & smask) == '0))
		else $error("placed square not aligned");

	// Bitmap rows are written only while marking a found square.
	a_write_in_mark: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_MARK && rsp_q.ok == 1'b0))
		else $error("bitmap write outside of marking");
`endif

endmodule

`default_nettype wire
